FILE: rtl/snx_pkg.sv
package snx_pkg;

  localparam int PermEntries = 256;
  localparam int PermAw      = 8;
  localparam int FrontDepth  = 4;
  localparam int OutDepth    = 32;

  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSample = 1'b1;

  // corner sum limit before the x32 scale, and saturated outputs
  localparam logic [63:0] SumLimit = 64'd536870912;
  localparam logic [35:0] OutMax   = 36'h4_0000_0000;
  localparam logic [35:0] OutMin   = 36'hC_0000_0000;

  typedef struct packed {
    logic                    func;
    logic [PermAw-1:0]       perm_index;
    logic [7:0]              perm_value;
    logic [63:0]             coord_x;
    logic [63:0]             coord_y;
    logic [63:0]             coord_z;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } issue_t;

endpackage

FILE: rtl/snx_fx_mul.sv
// signed (a*b) >> FRAC_BITS, low 64 bits; two register stages
module snx_fx_mul #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0]        p0_q;
  logic signed [64:0] p1_q, p2_q;
  logic signed [63:0] p3_q;
  logic [63:0]        p_q;

  logic signed [65:0] mid;
  logic [127:0]       full;
  logic [127:0]       mid_ext;

  always_ff @(posedge clk_i) begin
    p0_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    p1_q <= 65'($signed({1'b0, a_i[31:0]})) * 65'($signed(b_i[63:32]));
    p2_q <= 65'($signed(a_i[63:32])) * 65'($signed({1'b0, b_i[31:0]}));
    p3_q <= $signed(a_i[63:32]) * $signed(b_i[63:32]);
  end

  always_comb begin
    mid     = 66'(p1_q) + 66'(p2_q);
    mid_ext = {{62{mid[65]}}, mid};
    full    = {p3_q, 64'd0} + {mid_ext[95:0], 32'd0} + {64'd0, p0_q};
  end

  always_ff @(posedge clk_i) begin
    p_q <= full[FRAC_BITS+63:FRAC_BITS];
  end

  assign p_o = p_q;

endmodule

FILE: rtl/snx_delay.sv
module snx_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [N-1:0][W-1:0] sr_q;

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int n = 1; n < N; n++) begin
      sr_q[n] <= sr_q[n-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

FILE: rtl/snx_perm_ram.sv
// one permutation replica: one write port, two registered read ports
module snx_perm_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [snx_pkg::PermAw-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic [snx_pkg::PermAw-1:0] raddr0_i,
  input  logic [snx_pkg::PermAw-1:0] raddr1_i,
  output logic [7:0]                rdata0_o,
  output logic [7:0]                rdata1_o
);

  logic [7:0] mem_q [snx_pkg::PermEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

FILE: rtl/snx_front.sv
// input queue; issues samples to the core while output credits remain, loads at once
module snx_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  snx_pkg::item_t       item_i,
  input  logic                 out_pop_i,
  output snx_pkg::issue_t      issue_o
);

  localparam int PtrW  = $clog2(snx_pkg::FrontDepth);
  localparam int CntW  = $clog2(snx_pkg::FrontDepth + 1);
  localparam int CredW = $clog2(snx_pkg::OutDepth + 1);

  snx_pkg::item_t q_q [snx_pkg::FrontDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CredW-1:0] cred_q, cred_d;

  logic accept, issue, issue_smp;
  snx_pkg::item_t head;

  assign head   = q_q[rptr_q];
  assign full   = (cnt_q == CntW'(snx_pkg::FrontDepth));
  assign accept = push & ~full;
  // loads make no result and need no output slot
  assign issue  = (cnt_q != '0) &&
                  ((head.func == snx_pkg::FuncLoad) ||
                   (cred_q < CredW'(snx_pkg::OutDepth)));
  assign issue_smp = issue & (head.func == snx_pkg::FuncSample);

  always_comb begin
    cnt_d  = cnt_q + CntW'(accept) - CntW'(issue);
    cred_d = cred_q + CredW'(issue_smp) - CredW'(out_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      cred_q <= '0;
    end else begin
      if (accept) wptr_q <= wptr_q + 1'b1;
      if (issue)  rptr_q <= rptr_q + 1'b1;
      cnt_q  <= cnt_d;
      cred_q <= cred_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q[wptr_q] <= item_i;
    end
  end

  assign issue_o.valid = issue;
  assign issue_o.item  = head;

endmodule

FILE: rtl/snx_outq.sv
// result queue; sized so credited issues never overflow it
module snx_outq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  logic [35:0] wdata_i,
  input  logic        pop,
  output logic        empty,
  output logic [35:0] rdata_o
);

  localparam int PtrW = $clog2(snx_pkg::OutDepth);
  localparam int CntW = $clog2(snx_pkg::OutDepth + 1);

  logic [35:0]     mem_q [snx_pkg::OutDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            rd;

  assign empty   = (cnt_q == '0);
  assign rd      = pop & ~empty;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd)   rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(wr_i) - CntW'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/snx_core.sv
// fixed-latency noise pipeline; loads write each replica level at its lookup stage
module snx_core #(
  parameter int FRAC_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  snx_pkg::issue_t issue_i,
  output logic            res_valid_o,
  output logic [35:0]     res_o
);

  localparam int LastStage = 18;
  localparam int LoadStage = 7;

  localparam logic [63:0] FxOne     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FxF3      = FxOne / 3;
  localparam logic [63:0] FxG3      = FxOne / 6;
  localparam logic [63:0] FxG3x2    = FxOne / 3;
  localparam logic [63:0] FxHalf    = FxOne / 2;
  localparam logic [63:0] FxFalloff = (FxOne * 3) / 5;

  typedef logic [3:0][2:0][63:0] off_t;
  typedef logic [3:0][63:0]      quad_t;

  function automatic logic [3:0] mod12(input logic [7:0] h);
    logic [3:0] s;
    begin
      // h = 4q + r; q mod 3 by summing base-4 digits
      s = 4'(h[3:2]) + 4'(h[5:4]) + 4'(h[7:6]);
      if (s >= 4'd6) s = s - 4'd6;
      if (s >= 4'd3) s = s - 4'd3;
      mod12 = {s[1:0], h[1:0]};
    end
  endfunction

  function automatic logic [63:0] grad_dot(input logic [3:0] g, input logic [63:0] x,
                                           input logic [63:0] y, input logic [63:0] z);
    begin
      unique case (g)
        4'd0:    grad_dot =  x + y;
        4'd1:    grad_dot = -x + y;
        4'd2:    grad_dot =  x - y;
        4'd3:    grad_dot = -x - y;
        4'd4:    grad_dot =  x + z;
        4'd5:    grad_dot = -x + z;
        4'd6:    grad_dot =  x - z;
        4'd7:    grad_dot = -x - z;
        4'd8:    grad_dot =  y + z;
        4'd9:    grad_dot = -y + z;
        4'd10:   grad_dot =  y - z;
        4'd11:   grad_dot = -y - z;
        default: grad_dot = '0;
      endcase
    end
  endfunction

  // valid chains, reset
  logic [LastStage:0]   smp_q;
  logic [LoadStage+2:0] ld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
      ld_q  <= '0;
    end else begin
      smp_q <= {smp_q[LastStage-1:0],
                issue_i.valid & (issue_i.item.func == snx_pkg::FuncSample)};
      ld_q  <= {ld_q[LoadStage+1:0],
                issue_i.valid & (issue_i.item.func == snx_pkg::FuncLoad)};
    end
  end

  // stage A: capture, coordinate sum
  logic [63:0] a_x_q, a_y_q, a_z_q, a_sum_q;
  logic [15:0] a_ld_q;

  always_ff @(posedge clk_i) begin
    a_x_q   <= issue_i.item.coord_x;
    a_y_q   <= issue_i.item.coord_y;
    a_z_q   <= issue_i.item.coord_z;
    a_sum_q <= issue_i.item.coord_x + issue_i.item.coord_y + issue_i.item.coord_z;
    a_ld_q  <= {issue_i.item.perm_index, issue_i.item.perm_value};
  end

  logic [63:0]  skew_s;
  logic [191:0] a_xyz_dly;
  logic [15:0]  ld_dly;

  snx_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_s (
    .clk_i, .a_i(a_sum_q), .b_i(FxF3), .p_o(skew_s)
  );
  snx_delay #(.W(192), .N(2)) u_dly_a (
    .clk_i, .d_i({a_x_q, a_y_q, a_z_q}), .q_o(a_xyz_dly)
  );
  snx_delay #(.W(16), .N(LoadStage)) u_dly_ld (
    .clk_i, .d_i(a_ld_q), .q_o(ld_dly)
  );

  // each hash level reads in the cycle after the previous one, so its write
  // is delayed by a register likewise to keep loads and samples in order
  logic [15:0]      ld1_q, ld2_q;
  logic [2:0][15:0] ld_wr;

  always_ff @(posedge clk_i) begin
    ld1_q <= ld_dly;
    ld2_q <= ld1_q;
  end

  assign ld_wr = {ld2_q, ld1_q, ld_dly};

  // stage B: lattice cell
  logic [63:0] xs, ys, zs, ci, cj, ck;
  logic [63:0] b_x_q, b_y_q, b_z_q, b_i_q, b_j_q, b_k_q, b_ijk_q;

  always_comb begin
    xs = a_xyz_dly[191:128] + skew_s;
    ys = a_xyz_dly[127:64] + skew_s;
    zs = a_xyz_dly[63:0] + skew_s;
    ci = 64'($signed(xs) >>> FRAC_BITS);
    cj = 64'($signed(ys) >>> FRAC_BITS);
    ck = 64'($signed(zs) >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    b_x_q   <= a_xyz_dly[191:128];
    b_y_q   <= a_xyz_dly[127:64];
    b_z_q   <= a_xyz_dly[63:0];
    b_i_q   <= ci;
    b_j_q   <= cj;
    b_k_q   <= ck;
    b_ijk_q <= (ci + cj + ck) << FRAC_BITS;
  end

  logic [63:0]  unskew_t;
  logic [383:0] b_dly;

  snx_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t (
    .clk_i, .a_i(b_ijk_q), .b_i(FxG3), .p_o(unskew_t)
  );
  snx_delay #(.W(384), .N(2)) u_dly_b (
    .clk_i, .d_i({b_x_q, b_y_q, b_z_q, b_i_q, b_j_q, b_k_q}), .q_o(b_dly)
  );

  // stage C: in-cell offsets
  logic [63:0] c_x0_q, c_y0_q, c_z0_q;
  logic [7:0]  c_ii_q, c_jj_q, c_kk_q;

  always_ff @(posedge clk_i) begin
    c_x0_q <= b_dly[383:320] - ((b_dly[191:128] << FRAC_BITS) - unskew_t);
    c_y0_q <= b_dly[319:256] - ((b_dly[127:64] << FRAC_BITS) - unskew_t);
    c_z0_q <= b_dly[255:192] - ((b_dly[63:0] << FRAC_BITS) - unskew_t);
    c_ii_q <= b_dly[135:128];
    c_jj_q <= b_dly[71:64];
    c_kk_q <= b_dly[7:0];
  end

  // stage D: corner order and corner offsets
  logic       ge_xy, ge_yz, ge_xz;
  logic [2:0] o1, o2;   // {i, j, k}
  logic [3:0][2:0] cb_d;  // [corner][axis], axis 0 = x
  off_t       off_d;
  logic [63:0] base [3];

  always_comb begin
    ge_xy = $signed(c_x0_q) >= $signed(c_y0_q);
    ge_yz = $signed(c_y0_q) >= $signed(c_z0_q);
    ge_xz = $signed(c_x0_q) >= $signed(c_z0_q);
    if (ge_xy) begin
      if (ge_yz)      begin o1 = 3'b100; o2 = 3'b110; end
      else if (ge_xz) begin o1 = 3'b100; o2 = 3'b101; end
      else            begin o1 = 3'b001; o2 = 3'b101; end
    end else begin
      if (!ge_yz)     begin o1 = 3'b001; o2 = 3'b011; end
      else if (!ge_xz) begin o1 = 3'b010; o2 = 3'b011; end
      else            begin o1 = 3'b010; o2 = 3'b110; end
    end
    cb_d[0] = 3'b000;
    cb_d[1] = {o1[0], o1[1], o1[2]};
    cb_d[2] = {o2[0], o2[1], o2[2]};
    cb_d[3] = 3'b111;
    base[0] = c_x0_q;
    base[1] = c_y0_q;
    base[2] = c_z0_q;
    for (int a = 0; a < 3; a++) begin
      off_d[0][a] = base[a];
      off_d[1][a] = base[a] - (cb_d[1][a] ? FxOne : 64'd0) + FxG3;
      off_d[2][a] = base[a] - (cb_d[2][a] ? FxOne : 64'd0) + FxG3x2;
      off_d[3][a] = base[a] - FxOne + FxHalf;
    end
  end

  off_t            d_off_q;
  logic [3:0][2:0] d_cb_q;
  logic [7:0]      d_ii_q, d_jj_q, d_kk_q;

  always_ff @(posedge clk_i) begin
    d_off_q <= off_d;
    d_cb_q  <= cb_d;
    d_ii_q  <= c_ii_q;
    d_jj_q  <= c_jj_q;
    d_kk_q  <= c_kk_q;
  end

  // hash lookups: three levels, two replicas per level
  logic [2:0][3:0][7:0] raddr, rdata;
  logic [3:0][7:0]      e_jc_q, e_ic_q, f_ic_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      e_jc_q[c] <= d_jj_q + 8'(d_cb_q[c][1]);
      e_ic_q[c] <= d_ii_q + 8'(d_cb_q[c][0]);
    end
    f_ic_q <= e_ic_q;
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      raddr[0][c] = d_kk_q + 8'(d_cb_q[c][2]);
      raddr[1][c] = e_jc_q[c] + rdata[0][c];
      raddr[2][c] = f_ic_q[c] + rdata[1][c];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lvl
    for (genvar r = 0; r < 2; r++) begin : g_rep
      snx_perm_ram u_ram (
        .clk_i,
        .we_i     (ld_q[LoadStage+l]),
        .waddr_i  (ld_wr[l][15:8]),
        .wdata_i  (ld_wr[l][7:0]),
        .raddr0_i (raddr[l][2*r]),
        .raddr1_i (raddr[l][2*r+1]),
        .rdata0_o (rdata[l][2*r]),
        .rdata1_o (rdata[l][2*r+1])
      );
    end
  end

  // squared radius
  off_t sq;

  for (genvar c = 0; c < 4; c++) begin : g_sq_c
    for (genvar a = 0; a < 3; a++) begin : g_sq_a
      snx_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_sq (
        .clk_i, .a_i(d_off_q[c][a]), .b_i(d_off_q[c][a]), .p_o(sq[c][a])
      );
    end
  end

  quad_t tv_q;
  logic [3:0] neg;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      tv_q[c] <= FxFalloff - sq[c][0] - sq[c][1] - sq[c][2];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      neg[c] = tv_q[c][63];
    end
  end

  // gradient dot product
  off_t  off_dly;
  quad_t dot_q;

  snx_delay #(.W($bits(off_t)), .N(3)) u_dly_off (
    .clk_i, .d_i(d_off_q), .q_o(off_dly)
  );

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      dot_q[c] <= grad_dot(mod12(rdata[2][c]), off_dly[c][0], off_dly[c][1],
                           off_dly[c][2]);
    end
  end

  // falloff^4 times dot
  quad_t      tv2, tv4, dot_dly, prod;
  logic [3:0] neg_dly;

  snx_delay #(.W($bits(quad_t)), .N(3)) u_dly_dot (
    .clk_i, .d_i(dot_q), .q_o(dot_dly)
  );
  snx_delay #(.W(4), .N(6)) u_dly_neg (
    .clk_i, .d_i(neg), .q_o(neg_dly)
  );

  for (genvar c = 0; c < 4; c++) begin : g_fall
    snx_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_tv2 (
      .clk_i, .a_i(tv_q[c]), .b_i(tv_q[c]), .p_o(tv2[c])
    );
    snx_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_tv4 (
      .clk_i, .a_i(tv2[c]), .b_i(tv2[c]), .p_o(tv4[c])
    );
    snx_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_prod (
      .clk_i, .a_i(tv4[c]), .b_i(dot_dly[c]), .p_o(prod[c])
    );
  end

  // corner sum and saturation
  logic [63:0] sum_q;
  logic [35:0] res_q;
  quad_t       term;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      term[c] = neg_dly[c] ? 64'd0 : prod[c];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= term[0] + term[1] + term[2] + term[3];
    if ($signed(sum_q) > $signed(snx_pkg::SumLimit)) begin
      res_q <= snx_pkg::OutMax;
    end else if ($signed(sum_q) < -$signed(snx_pkg::SumLimit)) begin
      res_q <= snx_pkg::OutMin;
    end else begin
      res_q <= {sum_q[30:0], 5'd0};
    end
  end

  assign res_valid_o = smp_q[LastStage];
  assign res_o       = res_q;

endmodule

FILE: rtl/simplex_noise_3d_fixed_unit.sv
// 3D simplex noise, signed fixed point with FRAC_BITS fraction bits. A load
// item (func 0) writes one permutation byte and gives no result; a sample item
// (func 1) gives one saturated noise value. One item is taken every cycle
// while the input queue is not full: the core is a fixed pipeline of 19
// stages with 64-bit multiplies split into two-stage partial products, and the
// permutation table is held in six two-read-port copies so the four corners
// read each of the three hash levels in parallel. A 32-entry result queue
// with issue credits keeps that rate while the consumer pops at full speed;
// samples stop issuing only once 32 are outstanding in the core and the
// result queue. The table has no reset and must be loaded before sampling.
module simplex_noise_3d_fixed_unit #(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [7:0]         perm_index_i,
  input  logic [7:0]         perm_value_i,
  input  logic signed [63:0] coord_x_i,
  input  logic signed [63:0] coord_y_i,
  input  logic signed [63:0] coord_z_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [35:0] noise_value_o
);

  snx_pkg::item_t  item;
  snx_pkg::issue_t issue;
  logic            res_valid;
  logic [35:0]     res;
  logic [35:0]     head;
  logic            out_pop;

  assign item.func       = func_i;
  assign item.perm_index = perm_index_i;
  assign item.perm_value = perm_value_i;
  assign item.coord_x    = coord_x_i;
  assign item.coord_y    = coord_y_i;
  assign item.coord_z    = coord_z_i;

  assign out_pop = pop & ~empty;

  snx_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i(item), .out_pop_i(out_pop),
    .issue_o(issue)
  );

  snx_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk_i, .rst_ni, .issue_i(issue), .res_valid_o(res_valid), .res_o(res)
  );

  snx_outq u_outq (
    .clk_i, .rst_ni, .wr_i(res_valid), .wdata_i(res), .pop, .empty,
    .rdata_o(head)
  );

  assign noise_value_o = $signed(head);

endmodule
